>>> rtl/dse_pkg.sv
`timescale 1ns / 1ps

package dse_pkg;

   localparam int MaxItems   = 64;
   localparam int ValueWidth = 32;
   localparam int PosWidth   = 6;

   // broadcast from the controller to every cell of the chain
   typedef struct packed {
      logic                         insert;
      logic                         shift;
      logic signed [ValueWidth-1:0] ins_value;
   } cell_ctrl_type;

endpackage

>>> rtl/dse_cell.sv
`timescale 1ns / 1ps

module dse_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dse_pkg::cell_ctrl_type                ctrl,
   input  logic signed [dse_pkg::ValueWidth-1:0] upper_value,
   input  logic                                  upper_valid,
   input  logic                                  upper_greater,
   input  logic signed [dse_pkg::ValueWidth-1:0] lower_value,
   input  logic                                  lower_valid,
   output logic signed [dse_pkg::ValueWidth-1:0] value,
   output logic                                  valid,
   output logic                                  greater
);
   import dse_pkg::*;

   logic signed [ValueWidth-1:0] value_ff;
   logic signed [ValueWidth-1:0] value_in;
   logic                         valid_ff;
   logic                         valid_in;

   // an empty cell always loses, so the new value lands at the first free slot
   assign greater = !valid_ff || (ctrl.ins_value > value_ff);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = lower_value;
         valid_in = lower_valid;
      end else if (ctrl.insert) begin
         if (upper_greater) begin
            // the cell above takes the new value or shifts down, push ours down
            value_in = upper_value;
            valid_in = upper_valid;
         end else if (greater) begin
            value_in = ctrl.ins_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

>>> rtl/descending_sort_engine_unit.sv
`timescale 1ns / 1ps
// load: one transaction per cycle, each value in its place in the cell chain in the next cycle
// results: the first is offered in the cycle after the last input transaction,
//    then one per cycle while rsp_ready is high
// input is not taken while a run drains
// synchronous reset empties every cell and clears the overflow flag
module descending_sort_engine_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [dse_pkg::ValueWidth-1:0] req_value,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [dse_pkg::ValueWidth-1:0] rsp_value_res,
   output logic [dse_pkg::PosWidth-1:0]          rsp_position,
   output logic                                  rsp_last_out,
   output logic                                  rsp_overflow
);
   import dse_pkg::*;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

   state_type                    state_ff;
   logic [PosWidth-1:0]          position_ff;
   logic                         dropped_ff;

   cell_ctrl_type                ctrl;
   logic signed [ValueWidth-1:0] cell_value [MaxItems];
   logic [MaxItems-1:0]          cell_valid;
   logic [MaxItems-1:0]          cell_greater;

   logic                         req_fire;
   logic                         rsp_fire;
   logic                         full;

   assign full     = cell_valid[MaxItems-1];
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   assign ctrl.insert    = req_fire && !full;
   assign ctrl.shift     = rsp_fire;
   assign ctrl.ins_value = req_value;

   for (genvar i = 0; i < MaxItems; i++) begin : g_cell
      logic signed [ValueWidth-1:0] up_value;
      logic                         up_valid;
      logic                         up_greater;
      logic signed [ValueWidth-1:0] low_value;
      logic                         low_valid;

      if (i == 0) begin : g_head
         assign up_value   = '0;
         assign up_valid   = 1'b1;
         assign up_greater = 1'b0;
      end else begin : g_body
         assign up_value   = cell_value[i-1];
         assign up_valid   = cell_valid[i-1];
         assign up_greater = cell_greater[i-1];
      end

      if (i == MaxItems - 1) begin : g_tail
         assign low_value = '0;
         assign low_valid = 1'b0;
      end else begin : g_inner
         assign low_value = cell_value[i+1];
         assign low_valid = cell_valid[i+1];
      end

      dse_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .upper_value   (up_value),
         .upper_valid   (up_valid),
         .upper_greater (up_greater),
         .lower_value   (low_value),
         .lower_valid   (low_valid),
         .value         (cell_value[i]),
         .valid         (cell_valid[i]),
         .greater       (cell_greater[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         position_ff <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire && full) begin
                  dropped_ff <= 1'b1;
               end
               if (req_fire && req_last) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_fire) begin
                  position_ff <= position_ff + 1'b1;
                  if (rsp_last_out) begin
                     state_ff    <= ST_LOAD;
                     position_ff <= '0;
                     dropped_ff  <= 1'b0;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign req_ready     = (state_ff == ST_LOAD);
   assign rsp_valid     = (state_ff == ST_EMIT) && cell_valid[0];
   assign rsp_value_res = cell_value[0];
   assign rsp_position  = position_ff;
   assign rsp_last_out  = !cell_valid[1];
   assign rsp_overflow  = dropped_ff;

`ifndef ASSERT_OFF
   // occupied cells form an unbroken run from the head of the chain
   a_valid_contiguous: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid >> 1) & ~cell_valid) == '0)
      else $error("gap in occupied cells");

   // the chain stays sorted largest first at its head
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> (cell_value[0] >= cell_value[1]))
      else $error("head of chain out of order");

   // a full chain that gets one more transaction raises overflow
   a_drop_flags: assert property (@(posedge clock) disable iff (reset)
      (req_fire && full) |=> rsp_overflow)
      else $error("dropped transaction not flagged");

   // the final result leaves the chain empty and the block ready to load
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_out) |=> (!cell_valid[0] && req_ready && !rsp_overflow))
      else $error("chain not empty after final result");
`endif

endmodule
